[rtl/fsds_pkg.sv]
// Shared types and constants of the frame slot display scheduler.
package fsds_pkg;

	localparam int SLOTS = 3;
	localparam int SIDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_IDX_W-1:0] CFG_FRAME_PERIOD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PLAY_LENGTH = 1'd1;

	localparam logic [19:0] PERIOD_RESET = 20'd33333;
	localparam logic [31:0] LENGTH_RESET = 32'd3600000;

	// Divide by 1000 is done as a shift by three and a divide by 125.
	// The 45-bit shifted value is split at bit 24, and 2^24 = 125 * 134217 + 91.
	localparam logic [17:0] DIV_HI_MUL = 18'd134217;
	localparam logic [6:0] DIV_HI_REM = 7'd91;
	// Reciprocal of 125 scaled by 2^35, exact for dividends below 2^28.
	localparam logic [28:0] DIV_LO_MUL = 29'd274877907;
	localparam int DIV_LO_SHIFT = 35;
	// 1000 * 2^32: from here on the position saturates.
	localparam logic [47:0] POS_SAT_US = 48'd4294967296000;

	typedef enum logic [1:0] {
		OP_START = 2'd0,
		OP_CLAIM = 2'd1,
		OP_READY = 2'd2,
		OP_TICK = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		STAT_OK = 3'd0,
		STAT_NO_SLOT = 3'd1,
		STAT_NOT_PLAYING = 3'd2,
		STAT_ENDED = 3'd3,
		STAT_NOT_DUE = 3'd4,
		STAT_SHOWN = 3'd5,
		STAT_UNDERRUN = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		SLOT_EMPTY = 2'd0,
		SLOT_FILLING = 2'd1,
		SLOT_READY = 2'd2,
		SLOT_DISPLAYING = 2'd3
	} slot_state_t;

	// Item handed from the divider front end to the pool stage.
	typedef struct packed {
		op_t op;
		logic [2:0] sel;
		logic [47:0] now;
		logic [47:0] elapsed;
		logic [47:0] limit;
		logic limit_ok;
		logic sat;
		logic [31:0] pos_hi;
		logic [21:0] pos_lo;
	} work_t;

endpackage

[rtl/fsds_if.sv]
// Valid/ready channel interfaces for input items and result items.
interface fsds_item_if;
	logic valid;
	logic ready;
	logic [1:0] op;
	logic [2:0] slot_sel;
	logic [47:0] now_us;
	logic [47:0] elapsed_us;

	modport source(output valid, op, slot_sel, now_us, elapsed_us, input ready);
	modport sink(input valid, op, slot_sel, now_us, elapsed_us, output ready);
endinterface

interface fsds_result_if;
	logic valid;
	logic ready;
	logic [2:0] status;
	logic [2:0] slot_out;
	logic [47:0] shown_pts;
	logic [31:0] play_pos_ms;
	logic [2:0] dropped_now;
	logic [31:0] decoded_count;
	logic [31:0] dropped_count;
	logic [31:0] underrun_count;

	modport source(output valid, status, slot_out, shown_pts, play_pos_ms, dropped_now,
		decoded_count, dropped_count, underrun_count, input ready);
	modport sink(input valid, status, slot_out, shown_pts, play_pos_ms, dropped_now,
		decoded_count, dropped_count, underrun_count, output ready);
endinterface

[rtl/fsds_front.sv]
// Input register and the two stage divide by 1000 that feeds the pool stage.
module fsds_front (
	input logic clk,
	input logic arst_n,
	fsds_item_if.sink item,
	input logic [19:0] period,
	output logic work_valid,
	input logic work_ready,
	output fsds_pkg::work_t work
);

	typedef struct packed {
		fsds_pkg::op_t op;
		logic [2:0] sel;
		logic [47:0] now;
		logic [47:0] elapsed;
	} in_t;

	typedef struct packed {
		fsds_pkg::op_t op;
		logic [2:0] sel;
		logic [47:0] now;
		logic [47:0] elapsed;
		logic [47:0] limit;
		logic limit_ok;
		logic sat;
		logic [31:0] pos_hi;
		logic [27:0] rem;
	} mid_t;

	in_t in_s1;
	mid_t mid_s2;
	fsds_pkg::work_t work_s3;
	logic v_s1, v_s2, v_s3;
	logic adv_s1, adv_s2, adv_s3;

	logic [44:0] x;
	logic [38:0] hi_full;
	logic [56:0] lo_prod;
	mid_t mid_d;

	assign adv_s3 = !v_s3 || work_ready;
	assign adv_s2 = !v_s2 || adv_s3;
	assign adv_s1 = !v_s1 || adv_s2;
	assign item.ready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= item.valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_s3) v_s3 <= v_s2;
		end
	end

	// Stage one to two: split the shifted value and fold the high part.
	always_comb begin
		x = in_s1.elapsed[47:3];
		hi_full = 39'(x[44:24]) * 39'(fsds_pkg::DIV_HI_MUL);
		mid_d.op = in_s1.op;
		mid_d.sel = in_s1.sel;
		mid_d.now = in_s1.now;
		mid_d.elapsed = in_s1.elapsed;
		mid_d.limit = in_s1.elapsed - 48'(period);
		mid_d.limit_ok = in_s1.elapsed >= 48'(period);
		mid_d.sat = in_s1.elapsed >= fsds_pkg::POS_SAT_US;
		// Only used when not saturated, where the high part is below 2^32.
		mid_d.pos_hi = hi_full[31:0];
		mid_d.rem = 28'(x[44:24]) * 28'(fsds_pkg::DIV_HI_REM) + 28'(x[23:0]);
	end

	assign lo_prod = 57'(mid_s2.rem) * 57'(fsds_pkg::DIV_LO_MUL);

	always_ff @(posedge clk) begin
		if (adv_s1 && item.valid) begin
			in_s1.op <= fsds_pkg::op_t'(item.op);
			in_s1.sel <= item.slot_sel;
			in_s1.now <= item.now_us;
			in_s1.elapsed <= item.elapsed_us;
		end
		if (adv_s2 && v_s1) mid_s2 <= mid_d;
		if (adv_s3 && v_s2) begin
			work_s3.op <= mid_s2.op;
			work_s3.sel <= mid_s2.sel;
			work_s3.now <= mid_s2.now;
			work_s3.elapsed <= mid_s2.elapsed;
			work_s3.limit <= mid_s2.limit;
			work_s3.limit_ok <= mid_s2.limit_ok;
			work_s3.sat <= mid_s2.sat;
			work_s3.pos_hi <= mid_s2.pos_hi;
			work_s3.pos_lo <= lo_prod[fsds_pkg::DIV_LO_SHIFT+21:fsds_pkg::DIV_LO_SHIFT];
		end
	end

	assign work_valid = v_s3;
	assign work = work_s3;

endmodule

[rtl/fsds_pool.sv]
// Slot pool state, configuration registers, scheduling decisions and result register.
module fsds_pool (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [fsds_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [fsds_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic [19:0] period,
	input logic work_valid,
	output logic work_ready,
	input fsds_pkg::work_t work,
	fsds_result_if.source result
);

	localparam int SLOTS = fsds_pkg::SLOTS;
	localparam int SIDX_W = fsds_pkg::SIDX_W;

	logic [19:0] period_q;
	logic [31:0] length_q;

	fsds_pkg::slot_state_t state_q [SLOTS];
	logic [47:0] stamp_q [SLOTS];
	logic [SIDX_W-1:0] shown_q;
	logic shown_v_q;
	logic [47:0] last_q;
	logic [47:0] next_stamp_q;
	logic playing_q;
	logic [31:0] decoded_q, dropped_q, underrun_q;

	logic res_v_q;
	fsds_pkg::status_t res_status_q;
	logic [2:0] res_slot_q;
	logic [47:0] res_pts_q;
	logic [31:0] res_pos_q;
	logic [2:0] res_drop_q;

	fsds_pkg::slot_state_t state_d [SLOTS];
	logic [SIDX_W-1:0] shown_d;
	logic shown_v_d;
	logic [47:0] last_d;
	logic [47:0] next_stamp_d;
	logic playing_d;
	logic [31:0] decoded_d, dropped_d, underrun_d;
	logic stamp_we;
	logic [SIDX_W-1:0] sel_idx;
	fsds_pkg::status_t status_d;
	logic [2:0] slot_d;
	logic [47:0] pts_d;
	logic [31:0] pos_d;
	logic [2:0] drop_d;

	logic fire;
	logic [31:0] pos;
	logic sel_ok;
	logic found;
	logic [SIDX_W-1:0] pick;
	logic pick_v;

	assign work_ready = !res_v_q || result.ready;
	assign fire = work_valid && work_ready;
	assign period = period_q;
	assign sel_idx = work.sel[SIDX_W-1:0];
	assign sel_ok = {1'b0, work.sel} < 4'(SLOTS);
	assign pos = work.sat ? 32'hFFFF_FFFF : work.pos_hi + 32'(work.pos_lo);

	always_comb begin
		for (int i = 0; i < SLOTS; i++) state_d[i] = state_q[i];
		shown_d = shown_q;
		shown_v_d = shown_v_q;
		last_d = last_q;
		next_stamp_d = next_stamp_q;
		playing_d = playing_q;
		decoded_d = decoded_q;
		dropped_d = dropped_q;
		underrun_d = underrun_q;
		stamp_we = 1'b0;
		status_d = fsds_pkg::STAT_OK;
		slot_d = 3'd0;
		pts_d = 48'd0;
		pos_d = 32'd0;
		drop_d = 3'd0;
		found = 1'b0;
		pick = '0;
		pick_v = 1'b0;
		case (work.op)
			fsds_pkg::OP_START: begin
				for (int i = 0; i < SLOTS; i++) state_d[i] = fsds_pkg::SLOT_EMPTY;
				shown_d = '0;
				shown_v_d = 1'b0;
				next_stamp_d = 48'd0;
				decoded_d = 32'd0;
				dropped_d = 32'd0;
				underrun_d = 32'd0;
				playing_d = 1'b1;
				last_d = work.now;
			end
			fsds_pkg::OP_CLAIM: begin
				status_d = fsds_pkg::STAT_NO_SLOT;
				for (int i = 0; i < SLOTS; i++) begin
					if (!found && state_q[i] == fsds_pkg::SLOT_EMPTY) begin
						found = 1'b1;
						state_d[i] = fsds_pkg::SLOT_FILLING;
						status_d = fsds_pkg::STAT_OK;
						slot_d = 3'(i);
					end
				end
			end
			fsds_pkg::OP_READY: begin
				slot_d = work.sel;
				if (sel_ok && state_q[sel_idx] == fsds_pkg::SLOT_FILLING) begin
					stamp_we = 1'b1;
					pts_d = next_stamp_q;
					next_stamp_d = next_stamp_q + 48'(period_q);
					state_d[sel_idx] = fsds_pkg::SLOT_READY;
					decoded_d = decoded_q + 32'd1;
				end else begin
					status_d = fsds_pkg::STAT_NO_SLOT;
				end
			end
			fsds_pkg::OP_TICK: begin
				if (!playing_q) begin
					status_d = fsds_pkg::STAT_NOT_PLAYING;
				end else begin
					pos_d = pos;
					if (pos >= length_q) begin
						playing_d = 1'b0;
						status_d = fsds_pkg::STAT_ENDED;
					end else if ((work.now - last_q) < 48'(period_q)) begin
						status_d = fsds_pkg::STAT_NOT_DUE;
					end else begin
						if (shown_v_q) state_d[shown_q] = fsds_pkg::SLOT_EMPTY;
						// Lowest ready slot first; a later ready slot wins only if its stamp is already due and newer.
						for (int i = 0; i < SLOTS; i++) begin
							if (state_d[i] == fsds_pkg::SLOT_READY &&
								(!pick_v || (stamp_q[i] <= work.elapsed &&
								stamp_q[i] > stamp_q[pick]))) begin
								pick = SIDX_W'(i);
								pick_v = 1'b1;
							end
						end
						if (pick_v) begin
							if (work.limit_ok) begin
								for (int i = 0; i < SLOTS; i++) begin
									if (SIDX_W'(i) != pick &&
										state_d[i] == fsds_pkg::SLOT_READY &&
										stamp_q[i] < work.limit) begin
										state_d[i] = fsds_pkg::SLOT_EMPTY;
										drop_d = drop_d + 3'd1;
									end
								end
							end
							state_d[pick] = fsds_pkg::SLOT_DISPLAYING;
							shown_d = pick;
							shown_v_d = 1'b1;
							last_d = work.now;
							dropped_d = dropped_q + 32'(drop_d);
							status_d = fsds_pkg::STAT_SHOWN;
							slot_d = 3'(pick);
							pts_d = stamp_q[pick];
						end else begin
							shown_d = '0;
							shown_v_d = 1'b0;
							underrun_d = underrun_q + 32'd1;
							status_d = fsds_pkg::STAT_UNDERRUN;
						end
					end
				end
			end
			default: begin
				status_d = fsds_pkg::STAT_OK;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q <= fsds_pkg::PERIOD_RESET;
			length_q <= fsds_pkg::LENGTH_RESET;
			for (int i = 0; i < SLOTS; i++) state_q[i] <= fsds_pkg::SLOT_EMPTY;
			shown_q <= '0;
			shown_v_q <= 1'b0;
			last_q <= 48'd0;
			next_stamp_q <= 48'd0;
			playing_q <= 1'b0;
			decoded_q <= 32'd0;
			dropped_q <= 32'd0;
			underrun_q <= 32'd0;
			res_v_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					fsds_pkg::CFG_FRAME_PERIOD: period_q <= cfg_data[19:0];
					fsds_pkg::CFG_PLAY_LENGTH: length_q <= cfg_data[31:0];
					default: period_q <= period_q;
				endcase
			end
			if (fire) begin
				for (int i = 0; i < SLOTS; i++) state_q[i] <= state_d[i];
				shown_q <= shown_d;
				shown_v_q <= shown_v_d;
				last_q <= last_d;
				next_stamp_q <= next_stamp_d;
				playing_q <= playing_d;
				decoded_q <= decoded_d;
				dropped_q <= dropped_d;
				underrun_q <= underrun_d;
			end
			if (work_ready) res_v_q <= work_valid;
		end
	end

	// Stamps are only read while their slot is ready, so they need no reset.
	always_ff @(posedge clk) begin
		if (fire && stamp_we) stamp_q[sel_idx] <= next_stamp_q;
		if (fire) begin
			res_status_q <= status_d;
			res_slot_q <= slot_d;
			res_pts_q <= pts_d;
			res_pos_q <= pos_d;
			res_drop_q <= drop_d;
		end
	end

	assign result.valid = res_v_q;
	assign result.status = res_status_q;
	assign result.slot_out = res_slot_q;
	assign result.shown_pts = res_pts_q;
	assign result.play_pos_ms = res_pos_q;
	assign result.dropped_now = res_drop_q;
	assign result.decoded_count = decoded_q;
	assign result.dropped_count = dropped_q;
	assign result.underrun_count = underrun_q;

endmodule

[rtl/frame_slot_display_scheduler.sv]
// Top level of the frame slot display scheduler.
// Takes one item per clock cycle while the result side is ready and returns one result
// per item through an input register, two stages that divide the elapsed time by 1000
// through constant multiplies, and the pool stage that reads and updates the slot pool
// and loads the result register in the same cycle, and so sets the rate of one item per
// cycle. Stalls on the result side fill the empty stages first, so input is still taken
// while a result waits, until they are full. Configuration is written through cfg_we,
// cfg_index and cfg_data; the user must do so only while the block is idle (unchecked).
module frame_slot_display_scheduler (
	input logic clk,
	input logic arst_n,
	fsds_item_if.sink item,
	fsds_result_if.source result,
	input logic cfg_we,
	input logic [fsds_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [fsds_pkg::CFG_DATA_W-1:0] cfg_data
);

	logic [19:0] period;
	logic work_valid;
	logic work_ready;
	fsds_pkg::work_t work;

	fsds_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.period(period),
		.work_valid(work_valid),
		.work_ready(work_ready),
		.work(work)
	);

	fsds_pool u_pool (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.period(period),
		.work_valid(work_valid),
		.work_ready(work_ready),
		.work(work),
		.result(result)
	);

endmodule

[bench/frame_slot_display_scheduler_tb.sv]
// Self-checking testbench for the frame slot display scheduler with a scoreboard.
module frame_slot_display_scheduler_tb;

	localparam int PHASES = 7;
	localparam int RANDOM_PER_PHASE = 150;
	localparam int IDLE_LIMIT = 500;
	localparam int DRAIN_PAD = 10;
	localparam logic [63:0] US_PER_MS = 64'd1000;

	typedef struct packed {
		fsds_pkg::op_t op;
		logic [2:0] sel;
		logic [47:0] now;
		logic [47:0] elapsed;
	} sched_item_t;

	typedef struct packed {
		fsds_pkg::status_t status;
		logic [2:0] slot;
		logic [47:0] pts;
		logic [31:0] pos;
		logic [2:0] drop;
		logic [31:0] decoded;
		logic [31:0] dropped;
		logic [31:0] underruns;
	} sched_result_t;

	class frame_pool_scoreboard;
		logic [19:0] period;
		logic [31:0] length;
		fsds_pkg::slot_state_t slot_st[fsds_pkg::SLOTS];
		logic [47:0] slot_pts[fsds_pkg::SLOTS];
		logic [2:0] shown_idx;
		bit shown_vld;
		logic [47:0] last_show_now;
		logic [47:0] next_pts;
		bit playing;
		logic [31:0] decoded_total;
		logic [31:0] dropped_total;
		logic [31:0] underrun_total;
		sched_result_t pending_results[$];
		int mismatches;
		int checked;
		int shown_seen;
		int underrun_seen;
		int ended_seen;
		int drops_seen;

		function new();
			period = fsds_pkg::PERIOD_RESET;
			length = fsds_pkg::LENGTH_RESET;
			clear_pool();
			last_show_now = '0;
			playing = 1'b0;
			mismatches = 0;
			checked = 0;
			shown_seen = 0;
			underrun_seen = 0;
			ended_seen = 0;
			drops_seen = 0;
		endfunction

		function void clear_pool();
			for (int i = 0; i < fsds_pkg::SLOTS; i++) begin
				slot_st[i] = fsds_pkg::SLOT_EMPTY;
				slot_pts[i] = '0;
			end
			shown_idx = '0;
			shown_vld = 1'b0;
			next_pts = '0;
			decoded_total = '0;
			dropped_total = '0;
			underrun_total = '0;
		endfunction

		function void set_config(logic [fsds_pkg::CFG_IDX_W-1:0] idx,
			logic [fsds_pkg::CFG_DATA_W-1:0] data);
			if (idx == fsds_pkg::CFG_FRAME_PERIOD)
				period = data[19:0];
			else
				length = data;
		endfunction

		function int first_filling();
			int found;
			found = -1;
			for (int i = fsds_pkg::SLOTS - 1; i >= 0; i--)
				if (slot_st[i] == fsds_pkg::SLOT_FILLING)
					found = i;
			return found;
		endfunction

		function sched_result_t predict_display(sched_item_t it);
			sched_result_t r;
			int pick;
			bit found;
			logic [63:0] quot;
			logic [31:0] pos;
			logic [47:0] since_shown;
			logic [47:0] period48;
			logic [47:0] cutoff;
			r = '0;
			r.status = fsds_pkg::STAT_OK;
			period48 = {28'd0, period};
			case (it.op)
				fsds_pkg::OP_START: begin
					clear_pool();
					playing = 1'b1;
					last_show_now = it.now;
				end
				fsds_pkg::OP_CLAIM: begin
					r.status = fsds_pkg::STAT_NO_SLOT;
					found = 1'b0;
					for (int i = 0; i < fsds_pkg::SLOTS; i++) begin
						if (!found && slot_st[i] == fsds_pkg::SLOT_EMPTY) begin
							slot_st[i] = fsds_pkg::SLOT_FILLING;
							r.status = fsds_pkg::STAT_OK;
							r.slot = i[2:0];
							found = 1'b1;
						end
					end
				end
				fsds_pkg::OP_READY: begin
					r.slot = it.sel;
					if (it.sel < fsds_pkg::SLOTS &&
						slot_st[it.sel] == fsds_pkg::SLOT_FILLING) begin
						slot_pts[it.sel] = next_pts;
						r.pts = next_pts;
						next_pts = next_pts + period48;
						slot_st[it.sel] = fsds_pkg::SLOT_READY;
						decoded_total = decoded_total + 32'd1;
					end else begin
						r.status = fsds_pkg::STAT_NO_SLOT;
					end
				end
				fsds_pkg::OP_TICK: begin
					if (!playing) begin
						r.status = fsds_pkg::STAT_NOT_PLAYING;
					end else begin
						quot = {16'd0, it.elapsed} / US_PER_MS;
						pos = (quot > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : quot[31:0];
						r.pos = pos;
						since_shown = it.now - last_show_now;
						if (pos >= length) begin
							playing = 1'b0;
							r.status = fsds_pkg::STAT_ENDED;
						end else if (since_shown < period48) begin
							r.status = fsds_pkg::STAT_NOT_DUE;
						end else begin
							if (shown_vld)
								slot_st[shown_idx] = fsds_pkg::SLOT_EMPTY;
							// The lowest ready slot is the fallback; a later one wins only
							// if it is already due and newer than the current choice.
							pick = -1;
							for (int i = 0; i < fsds_pkg::SLOTS; i++) begin
								if (slot_st[i] == fsds_pkg::SLOT_READY) begin
									if (pick < 0)
										pick = i;
									else if (slot_pts[i] <= it.elapsed &&
										slot_pts[i] > slot_pts[pick])
										pick = i;
								end
							end
							if (pick >= 0) begin
								slot_st[pick] = fsds_pkg::SLOT_DISPLAYING;
								shown_idx = pick[2:0];
								shown_vld = 1'b1;
								last_show_now = it.now;
								if (it.elapsed >= period48) begin
									cutoff = it.elapsed - period48;
									for (int i = 0; i < fsds_pkg::SLOTS; i++) begin
										if (i != pick &&
											slot_st[i] == fsds_pkg::SLOT_READY &&
											slot_pts[i] < cutoff) begin
											slot_st[i] = fsds_pkg::SLOT_EMPTY;
											dropped_total = dropped_total + 32'd1;
											r.drop = r.drop + 3'd1;
										end
									end
								end
								r.status = fsds_pkg::STAT_SHOWN;
								r.slot = pick[2:0];
								r.pts = slot_pts[pick];
							end else begin
								shown_idx = '0;
								shown_vld = 1'b0;
								underrun_total = underrun_total + 32'd1;
								r.status = fsds_pkg::STAT_UNDERRUN;
							end
						end
					end
				end
			endcase
			r.decoded = decoded_total;
			r.dropped = dropped_total;
			r.underruns = underrun_total;
			return r;
		endfunction

		function void note_item(sched_item_t it);
			pending_results.push_back(predict_display(it));
		endfunction

		function string describe(sched_result_t r);
			return $sformatf(
				"status=%0d slot=%0d pts=%0h pos=%0d drop=%0d dec=%0d drp=%0d und=%0d",
				r.status, r.slot, r.pts, r.pos, r.drop, r.decoded, r.dropped, r.underruns);
		endfunction

		function void check_result(sched_result_t got);
			sched_result_t want;
			checked++;
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Result beat with nothing expected: %s", describe(got));
				return;
			end
			want = pending_results.pop_front();
			if (got !== want) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("Mismatch at result %0d", checked);
					$display("  expected %s", describe(want));
					$display("  actual   %s", describe(got));
				end
			end
			case (want.status)
				fsds_pkg::STAT_SHOWN: shown_seen++;
				fsds_pkg::STAT_UNDERRUN: underrun_seen++;
				fsds_pkg::STAT_ENDED: ended_seen++;
				default: ;
			endcase
			drops_seen += want.drop;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [fsds_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [fsds_pkg::CFG_DATA_W-1:0] cfg_data;

	fsds_item_if item_ch();
	fsds_result_if result_ch();

	frame_slot_display_scheduler u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_ch),
		.result(result_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	frame_pool_scoreboard sb;
	int items_sent = 0;
	int idle_cycles = 0;
	int tx_left = 0;
	bit tx_busy = 1'b0;
	int rx_left = 0;
	bit rx_busy = 1'b0;
	logic [47:0] tl_now = '0;
	logic [47:0] tl_el = '0;

	function automatic logic [47:0] rand48();
		logic [63:0] v;
		v = {$urandom, $urandom};
		return v[47:0];
	endfunction

	// Alternates runs of random waits with runs of back-to-back beats.
	function automatic int draw_wait(inout int run_left, inout bit run_busy);
		if (run_left == 0) begin
			run_busy = ($urandom_range(0, 3) != 0);
			run_left = $urandom_range(10, 50);
		end
		run_left--;
		return run_busy ? $urandom_range(0, 11) : 0;
	endfunction

	function automatic sched_item_t mk(fsds_pkg::op_t op, logic [2:0] sel, logic [47:0] now,
		logic [47:0] elapsed);
		sched_item_t it;
		it.op = op;
		it.sel = sel;
		it.now = now;
		it.elapsed = elapsed;
		return it;
	endfunction

	task automatic write_cfg(logic [fsds_pkg::CFG_IDX_W-1:0] idx,
		logic [fsds_pkg::CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.set_config(idx, data);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Valid stays high after a beat until the next call or stop_items().
	task automatic send_item(sched_item_t it);
		int wait_cycles;
		wait_cycles = draw_wait(tx_left, tx_busy);
		if (wait_cycles > 0) begin
			item_ch.valid <= 1'b0;
			repeat (wait_cycles) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.op <= it.op;
		item_ch.slot_sel <= it.sel;
		item_ch.now_us <= it.now;
		item_ch.elapsed_us <= it.elapsed;
		do @(posedge clk); while (!item_ch.ready);
		sb.note_item(it);
		items_sent++;
	endtask

	task automatic stop_items();
		item_ch.valid <= 1'b0;
	endtask

	task automatic drain();
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_PAD) @(posedge clk);
	endtask

	task automatic run_directed();
		logic [47:0] t0;
		t0 = 48'd1000;
		send_item(mk(fsds_pkg::OP_TICK, 3'd0, '0, '0));
		send_item(mk(fsds_pkg::OP_CLAIM, 3'd0, '0, '0));
		send_item(mk(fsds_pkg::OP_READY, 3'd0, '0, '0));
		send_item(mk(fsds_pkg::OP_READY, 3'd0, '0, '0));
		send_item(mk(fsds_pkg::OP_READY, 3'd7, '1, '1));
		send_item(mk(fsds_pkg::OP_START, 3'd0, t0, '0));
		// The fourth claim finds the pool full.
		repeat (4) send_item(mk(fsds_pkg::OP_CLAIM, 3'd7, '1, '1));
		for (int s = 0; s < fsds_pkg::SLOTS; s++)
			send_item(mk(fsds_pkg::OP_READY, s[2:0], '0, '0));
		send_item(mk(fsds_pkg::OP_TICK, 3'd0, t0 + 48'd10, '0));
		send_item(mk(fsds_pkg::OP_TICK, 3'd0, t0 + 48'd33333, '0));
		send_item(mk(fsds_pkg::OP_TICK, 3'd0, t0 + 48'd66666, 48'd200000));
		send_item(mk(fsds_pkg::OP_TICK, 3'd0, t0 + 48'd99999, 48'd250000));
		send_item(mk(fsds_pkg::OP_TICK, 3'd0, t0 + 48'd200000, 48'hFFFF_FFFF_FFFF));
		send_item(mk(fsds_pkg::OP_TICK, 3'd0, t0 + 48'd300000, '0));
		// Start just below the wrap point of the system time.
		send_item(mk(fsds_pkg::OP_START, 3'd0, 48'hFFFF_FFFF_FF9C, '0));
		send_item(mk(fsds_pkg::OP_TICK, 3'd0, 48'd50, '0));
		send_item(mk(fsds_pkg::OP_TICK, 3'd0, 48'd40000, 48'd5000));
		send_item(mk(fsds_pkg::OP_TICK, 3'd0, 48'd80000, 48'd4294967295999));
	endtask

	task automatic make_item(output sched_item_t it);
		int roll;
		int fill;
		int unsigned pstep;
		logic [47:0] dnow;
		roll = $urandom_range(0, 99);
		pstep = (sb.period == 0) ? $urandom_range(1, 20) : sb.period;
		it.op = fsds_pkg::OP_CLAIM;
		it.sel = 3'($urandom_range(0, 7));
		it.now = rand48();
		it.elapsed = rand48();
		if (roll < 10) begin
			it.op = fsds_pkg::op_t'($urandom_range(0, 3));
		end else if (roll < 14) begin
			it.op = fsds_pkg::OP_START;
			if ($urandom_range(0, 3) == 0)
				tl_now = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 3000000));
			else
				tl_now = rand48();
			tl_el = 48'($urandom_range(0, pstep));
			it.now = tl_now;
			it.elapsed = tl_el;
		end else if (roll < 40) begin
			it.op = fsds_pkg::OP_CLAIM;
		end else if (roll < 66) begin
			it.op = fsds_pkg::OP_READY;
			fill = sb.first_filling();
			if (fill >= 0 && $urandom_range(0, 4) != 0)
				it.sel = fill[2:0];
		end else begin
			it.op = fsds_pkg::OP_TICK;
			roll = $urandom_range(0, 99);
			if (roll < 75)
				dnow = 48'(pstep + $urandom_range(0, pstep / 4));
			else if (roll < 92)
				dnow = 48'($urandom_range(0, pstep));
			else
				dnow = 48'(2 * pstep);
			tl_now = tl_now + dnow;
			// Elapsed time mostly tracks the ticks, sometimes jumps ahead so that
			// frames go late, and sometimes lags so that stamps lie in the future.
			roll = $urandom_range(0, 99);
			if (roll < 1)
				tl_el = rand48();
			else if (roll < 15)
				tl_el = tl_el + dnow + 48'(pstep * $urandom_range(1, 4));
			else if (roll < 25)
				tl_el = tl_el + 48'($urandom_range(0, pstep / 2));
			else
				tl_el = tl_el + dnow;
			it.now = tl_now;
			it.elapsed = tl_el;
		end
	endtask

	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("No beat moved for %0d cycles, %0d results outstanding",
				idle_cycles, sb.pending());
			$display("Test completed with failures");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		int wait_cycles;
		sched_result_t got;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			wait_cycles = draw_wait(rx_left, rx_busy);
			if (wait_cycles > 0) begin
				result_ch.ready <= 1'b0;
				repeat (wait_cycles) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (result_ch.valid !== 1'b1);
			got.status = fsds_pkg::status_t'(result_ch.status);
			got.slot = result_ch.slot_out;
			got.pts = result_ch.shown_pts;
			got.pos = result_ch.play_pos_ms;
			got.drop = result_ch.dropped_now;
			got.decoded = result_ch.decoded_count;
			got.dropped = result_ch.dropped_count;
			got.underruns = result_ch.underrun_count;
			sb.check_result(got);
		end
	end

	initial begin
		sched_item_t it;
		logic [31:0] period_set;
		logic [31:0] length_set;
		sb = new();
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= fsds_pkg::CFG_FRAME_PERIOD;
		cfg_data <= '0;
		item_ch.valid <= 1'b0;
		item_ch.op <= fsds_pkg::OP_START;
		item_ch.slot_sel <= '0;
		item_ch.now_us <= '0;
		item_ch.elapsed_us <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int phase = 0; phase < PHASES; phase++) begin
			case (phase)
				0: begin
					period_set = 32'(fsds_pkg::PERIOD_RESET);
					length_set = fsds_pkg::LENGTH_RESET;
				end
				1: begin period_set = 32'd1; length_set = 32'd0; end
				2: begin period_set = 32'd1000000; length_set = 32'hFFFF_FFFF; end
				3: begin period_set = 32'd0; length_set = 32'd50; end
				// Bits above the 20-bit period field must be discarded.
				4: begin period_set = 32'hFFFF_FFFF; length_set = 32'd1000000; end
				5: begin
					period_set = $urandom_range(1, 5000);
					length_set = $urandom_range(20, 2000);
				end
				default: begin
					period_set = 32'(fsds_pkg::PERIOD_RESET);
					length_set = $urandom_range(100, 20000);
				end
			endcase
			write_cfg(fsds_pkg::CFG_FRAME_PERIOD, period_set);
			write_cfg(fsds_pkg::CFG_PLAY_LENGTH, length_set);
			if (phase == 0)
				run_directed();
			for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
				if (n == RANDOM_PER_PHASE / 2) begin
					stop_items();
					drain();
				end
				make_item(it);
				send_item(it);
			end
			stop_items();
			drain();
		end
		if (sb.pending() != 0)
			$display("%0d expected results never arrived", sb.pending());
		$display("Run covered %0d input beats and %0d result beats over %0d register settings.",
			items_sent, sb.checked, PHASES);
		$display("Frames shown %0d, underruns %0d, playback ends %0d, late frames dropped %0d.",
			sb.shown_seen, sb.underrun_seen, sb.ended_seen, sb.drops_seen);
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d mismatches", sb.mismatches);
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
